// ===== sv/hsv_to_rgb_converter_macros.svh =====
// assertion macros shared by the hsv to rgb converter modules
`ifndef HSV_TO_RGB_CONVERTER_MACROS_SVH
`define HSV_TO_RGB_CONVERTER_MACROS_SVH

// same-cycle implication, off while in reset
`define H2R_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while in reset
`define H2R_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/h2r_pkg.sv =====
// shared types and constants of the hsv to rgb converter
`default_nettype none

package h2r_pkg;

    localparam int CH_W       = 8;
    localparam int CH_MAX     = 255;
    localparam int SECTOR_DEG = 60;
    localparam int FULL_DEG   = 360;
    localparam int NUM_MULT   = 6;

    // hue sector, picks which channel holds max, mid and min
    typedef enum logic [2:0] {
        SEC_R_TO_Y = 3'd0,
        SEC_Y_TO_G = 3'd1,
        SEC_G_TO_C = 3'd2,
        SEC_C_TO_B = 3'd3,
        SEC_B_TO_M = 3'd4,
        SEC_M_TO_R = 3'd5
    } t_sector;

    typedef struct packed {
        t_sector           sector;
        logic [CH_W-1:0]   sat;
        logic [CH_W-1:0]   val;
    } t_job;

endpackage

`default_nettype wire

// ===== sv/h2r_if.sv =====
// stream interfaces for hsv input and rgb output
`default_nettype none

interface h2r_hsv_if import h2r_pkg::*; #(
    parameter int HUE_W = 13
);
    logic              valid;
    logic              ready;
    logic [HUE_W-1:0]  hue;
    logic [CH_W-1:0]   saturation;
    logic [CH_W-1:0]   brightness;

    modport source (output valid, output hue, output saturation, output brightness,
                    input ready);
    modport sink   (input valid, input hue, input saturation, input brightness,
                    output ready);
endinterface

interface h2r_rgb_if import h2r_pkg::*;;
    logic             valid;
    logic             ready;
    logic [CH_W-1:0]  red;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

`default_nettype wire

// ===== sv/h2r_front.sv =====
// front end: takes hsv transfers, finds sector and sector distance
`default_nettype none
`include "hsv_to_rgb_converter_macros.svh"

module h2r_front import h2r_pkg::*; #(
    parameter int HUE_FRAC_BITS = 4,
    parameter int HUE_W         = 13,
    parameter int K_W           = 10
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    h2r_hsv_if.sink         i_hsv,
    output logic            o_valid,
    input  logic            i_fifo_ready,
    output logic [K_W-1:0]  o_k,
    output t_job            o_job
);
    localparam int P        = SECTOR_DEG << HUE_FRAC_BITS;
    localparam int HUE_FULL = FULL_DEG << HUE_FRAC_BITS;

    logic             w_ready;
    logic [HUE_W-1:0] w_hs;
    logic [HUE_W-1:0] w_base;
    logic [HUE_W-1:0] w_t;
    logic [2:0]       w_q;
    logic [K_W-1:0]   n_k;
    t_sector          n_sector;
    logic             r_valid;
    logic             n_valid;
    logic [K_W-1:0]   r_k;
    t_job             r_job;

    always_comb begin
        w_hs = (i_hsv.hue > HUE_W'(HUE_FULL)) ? HUE_W'(HUE_FULL) : i_hsv.hue;
        // number of whole sectors below the hue
        w_q = '0;
        for (int j = 1; j <= NUM_MULT; j++) begin
            if (w_hs >= HUE_W'(j * P)) begin
                w_q = 3'(j);
            end
        end
    end

    always_comb begin
        unique case (w_q[2:1])
            2'd0:    w_base = '0;
            2'd1:    w_base = HUE_W'(2 * P);
            2'd2:    w_base = HUE_W'(4 * P);
            default: w_base = HUE_W'(6 * P);
        endcase
        w_t = w_hs - w_base;
        // distance term p - |t - p|
        n_k = (w_t >= HUE_W'(P)) ? K_W'(HUE_W'(2 * P) - w_t) : K_W'(w_t);
    end

    always_comb begin
        unique case (w_q)
            3'd0:    n_sector = SEC_R_TO_Y;
            3'd1:    n_sector = SEC_Y_TO_G;
            3'd2:    n_sector = SEC_G_TO_C;
            3'd3:    n_sector = SEC_C_TO_B;
            3'd4:    n_sector = SEC_B_TO_M;
            default: n_sector = SEC_M_TO_R;
        endcase
    end

    assign w_ready     = !r_valid || i_fifo_ready;
    assign n_valid     = w_ready ? i_hsv.valid : r_valid;
    assign i_hsv.ready = w_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready && i_hsv.valid) begin
            r_k          <= n_k;
            r_job.sector <= n_sector;
            r_job.sat    <= i_hsv.saturation;
            r_job.val    <= i_hsv.brightness;
        end
    end

    assign o_valid = r_valid;
    assign o_k     = r_k;
    assign o_job   = r_job;

    `H2R_ASSERT_NEXT(a_front_hold, i_clk, i_rst_n, r_valid && !i_fifo_ready,
        r_valid && $stable(r_k) && $stable(r_job), "front register lost a stalled item")

endmodule

`default_nettype wire

// ===== sv/h2r_fifo.sv =====
// small queue between front end and arithmetic pipeline
`default_nettype none
`include "hsv_to_rgb_converter_macros.svh"

module h2r_fifo import h2r_pkg::*; #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    output logic             o_push_ready,
    input  logic [WIDTH-1:0] i_push_data,
    output logic             o_pop_valid,
    input  logic             i_pop_ready,
    output logic [WIDTH-1:0] o_pop_data
);
    localparam int AW    = $clog2(DEPTH);
    localparam int CNT_W = AW + 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push;
    logic             w_pop;

    assign o_push_ready = (r_count != CNT_W'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;
    assign o_pop_data   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `H2R_ASSERT_IMPL(a_fifo_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(DEPTH),
        "queue count beyond depth")
    `H2R_ASSERT_NEXT(a_fifo_fill, i_clk, i_rst_n, w_push && !w_pop,
        r_count == $past(r_count) + 1'b1, "queue count missed a push")

endmodule

`default_nettype wire

// ===== sv/h2r_back.sv =====
// arithmetic pipeline: products, reciprocal divide, channel order
`default_nettype none
`include "hsv_to_rgb_converter_macros.svh"

module h2r_back import h2r_pkg::*; #(
    parameter int HUE_FRAC_BITS = 4,
    parameter int K_W           = 10
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [K_W-1:0]  i_k,
    input  t_job            i_job,
    h2r_rgb_if.source       o_rgb
);
    localparam int PW = 2 * CH_W;
    localparam int NW = 2 * CH_W + K_W;
    // sector width is 15 << (frac bits + 2), so v*s*k / width is a shift and a
    // divide by 15; the reciprocal multiply below is exact for dividends below 2^20
    localparam int YW       = 20;
    localparam int RW       = 21;
    localparam int QW       = YW + RW;
    localparam int RS       = 24;
    localparam int RECIP_15 = 1118482;

    logic en;

    // stage 1: v*(1-s) and v*s
    logic            r1_vld;
    logic [PW-1:0]   r1_a;
    logic [PW-1:0]   r1_b;
    logic [K_W-1:0]  r1_k;
    logic [CH_W-1:0] r1_v;
    t_sector         r1_sec;
    logic [PW:0]     w_lo_sum;

    // stage 2: v*s*k and low channel
    logic            r2_vld;
    logic [PW-1:0]   r2_a;
    logic [NW-1:0]   r2_bk;
    logic [CH_W-1:0] r2_lo;
    logic [CH_W-1:0] r2_v;
    t_sector         r2_sec;
    logic [YW-1:0]   w_y;

    // stage 3: reciprocal product for the divide by 15
    logic            r3_vld;
    logic [QW-1:0]   r3_prod;
    logic [PW-1:0]   r3_a;
    logic [CH_W-1:0] r3_lo;
    logic [CH_W-1:0] r3_v;
    t_sector         r3_sec;
    logic [PW-1:0]   w_u;

    // stage 4: mid channel sum, floor by 255 follows
    logic            r4_vld;
    logic [PW-1:0]   r4_z;
    logic [CH_W-1:0] r4_lo;
    logic [CH_W-1:0] r4_v;
    t_sector         r4_sec;
    logic [PW:0]     w_mid_sum;

    logic            r_out_valid;
    logic [CH_W-1:0] r_red;
    logic [CH_W-1:0] r_green;
    logic [CH_W-1:0] r_blue;
    logic [CH_W-1:0] n_red;
    logic [CH_W-1:0] n_green;
    logic [CH_W-1:0] n_blue;
    logic [CH_W-1:0] w_hi;
    logic [CH_W-1:0] w_mid;
    logic [CH_W-1:0] w_lo;

    logic [3:0]      w_vld_vec;

    assign en      = !r_out_valid || o_rgb.ready;
    assign o_ready = en;

    // floor(a/255) for a up to 255*255
    assign w_lo_sum  = {1'b0, r1_a} + (PW+1)'(r1_a >> CH_W) + (PW+1)'(1);
    assign w_y       = YW'(r2_bk >> (HUE_FRAC_BITS + 2));
    assign w_u       = r3_prod[RS +: PW];
    // mid = floor((v*(255-s) + floor(v*s*k / width)) / 255)
    assign w_mid_sum = {1'b0, r4_z} + (PW+1)'(r4_z >> CH_W) + (PW+1)'(1);

    assign w_hi  = r4_v;
    assign w_mid = w_mid_sum[PW-1:CH_W];
    assign w_lo  = r4_lo;

    always_comb begin
        unique case (r4_sec)
            SEC_R_TO_Y: begin n_red = w_hi;  n_green = w_mid; n_blue = w_lo;  end
            SEC_Y_TO_G: begin n_red = w_mid; n_green = w_hi;  n_blue = w_lo;  end
            SEC_G_TO_C: begin n_red = w_lo;  n_green = w_hi;  n_blue = w_mid; end
            SEC_C_TO_B: begin n_red = w_lo;  n_green = w_mid; n_blue = w_hi;  end
            SEC_B_TO_M: begin n_red = w_mid; n_green = w_lo;  n_blue = w_hi;  end
            default:    begin n_red = w_hi;  n_green = w_lo;  n_blue = w_mid; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld      <= 1'b0;
            r2_vld      <= 1'b0;
            r3_vld      <= 1'b0;
            r4_vld      <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r1_vld      <= i_valid;
            r2_vld      <= r1_vld;
            r3_vld      <= r2_vld;
            r4_vld      <= r3_vld;
            r_out_valid <= r4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_a    <= PW'(i_job.val) * PW'(CH_W'(CH_MAX) - i_job.sat);
            r1_b    <= PW'(i_job.val) * PW'(i_job.sat);
            r1_k    <= i_k;
            r1_v    <= i_job.val;
            r1_sec  <= i_job.sector;

            r2_a    <= r1_a;
            r2_bk   <= NW'(r1_b) * NW'(r1_k);
            r2_lo   <= w_lo_sum[PW-1:CH_W];
            r2_v    <= r1_v;
            r2_sec  <= r1_sec;

            r3_prod <= QW'(w_y) * QW'(RECIP_15);
            r3_a    <= r2_a;
            r3_lo   <= r2_lo;
            r3_v    <= r2_v;
            r3_sec  <= r2_sec;

            r4_z    <= r3_a + w_u;
            r4_lo   <= r3_lo;
            r4_v    <= r3_v;
            r4_sec  <= r3_sec;

            r_red   <= n_red;
            r_green <= n_green;
            r_blue  <= n_blue;
        end
    end

    assign o_rgb.valid = r_out_valid;
    assign o_rgb.red   = r_red;
    assign o_rgb.green = r_green;
    assign o_rgb.blue  = r_blue;

    assign w_vld_vec = {r1_vld, r2_vld, r3_vld, r4_vld};

    `H2R_ASSERT_NEXT(a_back_freeze, i_clk, i_rst_n, r_out_valid && !o_rgb.ready,
        $stable(w_vld_vec) && r_out_valid, "pipeline moved while output stalled")

endmodule

`default_nettype wire

// ===== sv/hsv_to_rgb_converter.sv =====
// top level of the hsv to rgb color converter
//
//  channel  dir  payload                              transfer when
//  i_hsv    in   hue, saturation, brightness          valid && ready
//  o_rgb    out  red, green, blue (8 bit each)        valid && ready
//
//  one color per clock sustained while o_rgb.ready stays high; an input transfer passes the
//  front register, queue, two product stages, reciprocal multiply, sum and output register
//  the mid channel divide by 255*sector width is shifts, a reciprocal multiply by 1/15
//  and a shift-add floor by 255
//  reset clears valid flags, queue pointers and queue count only, no clearing pass
//  an output stall freezes the arithmetic pipeline; queue and front register absorb
//  up to five more transfers before i_hsv.ready drops
`default_nettype none

module hsv_to_rgb_converter import h2r_pkg::*; #(
    parameter int HUE_FRAC_BITS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    h2r_hsv_if.sink     i_hsv,
    h2r_rgb_if.source   o_rgb
);
    // sector width and full circle in hue units
    localparam int P        = SECTOR_DEG << HUE_FRAC_BITS;
    localparam int HUE_FULL = FULL_DEG << HUE_FRAC_BITS;
    localparam int HUE_W    = $clog2(HUE_FULL + 1);
    // distance term k runs 0..P
    localparam int K_W      = $clog2(P + 1);
    localparam int Q_W      = K_W + $bits(t_job);
    localparam int Q_DEPTH  = 4;

    // front to queue
    logic           w_fr_valid;
    logic           w_fr_ready;
    logic [K_W-1:0] w_fr_k;
    t_job           w_fr_job;

    // queue to back end
    logic           w_bk_valid;
    logic           w_bk_ready;
    logic [Q_W-1:0] w_bk_data;
    logic [K_W-1:0] w_bk_k;
    t_job           w_bk_job;

    // hue clamp, sector pick and distance term
    h2r_front #(
        .HUE_FRAC_BITS (HUE_FRAC_BITS),
        .HUE_W         (HUE_W),
        .K_W           (K_W)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_hsv        (i_hsv),
        .o_valid      (w_fr_valid),
        .i_fifo_ready (w_fr_ready),
        .o_k          (w_fr_k),
        .o_job        (w_fr_job)
    );

    // decouples classification from the long arithmetic pipeline
    h2r_fifo #(
        .WIDTH (Q_W),
        .DEPTH (Q_DEPTH)
    ) u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_fr_valid),
        .o_push_ready (w_fr_ready),
        .i_push_data  ({w_fr_k, w_fr_job}),
        .o_pop_valid  (w_bk_valid),
        .i_pop_ready  (w_bk_ready),
        .o_pop_data   (w_bk_data)
    );

    assign w_bk_k   = w_bk_data[Q_W-1 -: K_W];
    assign w_bk_job = t_job'(w_bk_data[$bits(t_job)-1:0]);

    // chroma products, exact divides, channel ordering
    h2r_back #(
        .HUE_FRAC_BITS (HUE_FRAC_BITS),
        .K_W           (K_W)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_bk_valid),
        .o_ready (w_bk_ready),
        .i_k     (w_bk_k),
        .i_job   (w_bk_job),
        .o_rgb   (o_rgb)
    );

endmodule

`default_nettype wire
